// File: src/merge_and_sort_two_arrays_macros.svh
// Assertion macros used by the sorting collector top level.
// Each macro expects clk and rst_n in scope at the place of use.
`ifndef MERGE_AND_SORT_TWO_ARRAYS_MACROS_SVH
`define MERGE_AND_SORT_TWO_ARRAYS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MAST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MAST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: src/mast_pkg.sv
// Package for the sorting collector: payload structs, cell control, FSM states.
// No dependencies.
`timescale 1ns / 1ps

package mast_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value_in;
    logic                     is_last;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value_out;
    logic                     last_out;
    logic                     overflow;
  } out_t;

  // Per-cycle command broadcast along the cell chain
  typedef struct packed {
    logic ins;    // insert the broadcast value in order
    logic drain;  // shift every cell one place toward the head
  } cell_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

// File: src/mast_cell.sv
// One cell of the insertion chain: holds one stored value.
// Depends on mast_pkg.
`timescale 1ns / 1ps

module mast_cell (
  input  logic                             clk,
  input  mast_pkg::cell_ctl_t              ctl,
  input  logic                             occ,       // this cell holds a live value
  input  logic signed [mast_pkg::DATA_W-1:0] new_val, // broadcast insert value
  input  logic signed [mast_pkg::DATA_W-1:0] prev_val,
  input  logic                             prev_le,   // previous cell keeps its value
  input  logic signed [mast_pkg::DATA_W-1:0] next_val,
  output logic signed [mast_pkg::DATA_W-1:0] val,
  output logic                             le
);
  import mast_pkg::*;

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;

  assign val = val_r;
  assign le  = occ && (val_r <= new_val);

  always_comb begin
    val_nxt = val_r;
    if (ctl.drain) begin
      val_nxt = next_val;
    end else if (ctl.ins && !le) begin
      // the new value lands here if everything before it stays put
      val_nxt = prev_le ? new_val : prev_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: src/merge_and_sort_two_arrays.sv
// Top level of the sorting collector: cell chain, fill count and control FSM.
// Depends on mast_pkg, mast_cell and merge_and_sort_two_arrays_macros.svh.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_ready  | in_data  (mast_pkg::in_t)
//   out_    | output    | out_valid/out_ready| out_data (mast_pkg::out_t)
//
// Loading accepts one element per cycle: every cell compares against the
// broadcast value in parallel and the chain shifts by one behind the insert point.
// After the closing element the set streams out of the head cell, one per cycle,
// while input is held off; output stalls simply hold the chain.
// Synchronous active-low reset clears the count, overflow flag and FSM only.
`timescale 1ns / 1ps

module merge_and_sort_two_arrays #(
  parameter int CAPACITY = mast_pkg::CAPACITY
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mast_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mast_pkg::out_t out_data
);
  import mast_pkg::*;
  `include "merge_and_sort_two_arrays_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;

  logic             in_acc, out_acc, full, last_one;
  cell_ctl_t        ctl;

  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic                     cell_le  [CAPACITY];

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign full     = (cnt_r == CNT_W'(CAPACITY));
  assign last_one = (cnt_r == CNT_W'(1));

  assign ctl.ins   = in_acc && !full;
  assign ctl.drain = out_acc;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] pv, nv;
      logic                     ple;
      if (i == 0) begin : g_head
        assign pv  = '0;
        assign ple = 1'b1;
      end else begin : g_body
        assign pv  = cell_val[i-1];
        assign ple = cell_le[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign nv = '0;
      end else begin : g_mid
        assign nv = cell_val[i+1];
      end
      mast_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .occ      (cnt_r > CNT_W'(i)),
        .new_val  (in_data.value_in),
        .prev_val (pv),
        .prev_le  (ple),
        .next_val (nv),
        .val      (cell_val[i]),
        .le       (cell_le[i])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_data.is_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_acc && last_one) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_LOAD:  in_ready  = 1'b1;
      ST_DRAIN: out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  assign out_data.value_out = cell_val[0];
  assign out_data.last_out  = last_one;
  assign out_data.overflow  = ovf_r;

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (in_acc) begin
      if (full) ovf_nxt = 1'b1;   // drop the element, flag the set
      else      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (out_acc) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (last_one) ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  `MAST_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
  `MAST_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(CAPACITY))
  `MAST_ASSERT_IMP(a_drain_nonempty, state_r == ST_DRAIN, cnt_r != '0)
  `MAST_ASSERT_NXT(a_reload, out_acc && out_data.last_out, in_ready && cnt_r == '0 && !ovf_r)

endmodule

// File: verif/tb_top.sv
// Testbench for merge_and_sort_two_arrays: sends sets of signed elements and checks
// each sorted result stream against an insertion-sort model kept here.
// Depends on mast_pkg and the merge_and_sort_two_arrays RTL.
`timescale 1ns / 1ps

module tb_top;
  import mast_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4 * CAPACITY + 20;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Sorting model state
  logic signed [DATA_W-1:0] model_buf [CAPACITY];
  int model_fill = 0;
  bit model_dropped = 1'b0;
  out_t pending_sorted[$];
  out_t exp_r;

  logic signed [DATA_W-1:0] set_vals[$];
  int errors = 0;
  int elems_sent = 0;
  int sets_sent = 0;
  int results_seen = 0;
  int overflow_sets = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  int stall_left = 0;
  int ready_pick;
  int cycles = 0;

  merge_and_sort_two_arrays #(.CAPACITY(CAPACITY)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run timed out after %0d cycles", $time, cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Insert one element in order; on the closing element queue the sorted set.
  task automatic absorb_element(input in_t t);
    int pos;
    int k;
    logic signed [DATA_W-1:0] v;
    out_t r;
    v = t.value_in;
    if (model_fill >= CAPACITY) begin
      model_dropped = 1'b1;
    end else begin
      pos = model_fill;
      while (pos > 0 && model_buf[pos-1] > v) begin
        model_buf[pos] = model_buf[pos-1];
        pos--;
      end
      model_buf[pos] = v;
      model_fill++;
    end
    if (t.is_last) begin
      for (k = 0; k < model_fill; k++) begin
        r.value_out = model_buf[k];
        r.last_out = (k == model_fill - 1);
        r.overflow = model_dropped;
        pending_sorted.push_back(r);
      end
      if (model_dropped) overflow_sets++;
      model_fill = 0;
      model_dropped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) absorb_element(in_data);
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_sorted.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, value_out %0d last_out %0b overflow %0b",
                   $time, $signed(out_data.value_out), out_data.last_out, out_data.overflow);
        end else begin
          exp_r = pending_sorted.pop_front();
          if (out_data.value_out !== exp_r.value_out) begin
            errors++;
            $display("%0t: value_out expected %0d got %0d", $time,
                     $signed(exp_r.value_out), $signed(out_data.value_out));
          end
          if (out_data.last_out !== exp_r.last_out) begin
            errors++;
            $display("%0t: last_out expected %0b got %0b", $time,
                     exp_r.last_out, out_data.last_out);
          end
          if (out_data.overflow !== exp_r.overflow) begin
            errors++;
            $display("%0t: overflow expected %0b got %0b", $time,
                     exp_r.overflow, out_data.overflow);
          end
        end
      end
    end
  end

  // Backpressure on the result side while out_idle_on is set: short stalls often, long ones now and then.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!out_idle_on) begin
      out_ready <= 1'b1;
    end else begin
      ready_pick = $urandom_range(0, 19);
      if (ready_pick == 0) begin
        stall_left = $urandom_range(8, 30);
        out_ready <= 1'b0;
      end else begin
        out_ready <= (ready_pick >= 6);
      end
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 19) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_element();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    if (r < 8) return $urandom_range(0, 8) - 4;
    if (r == 8) return VAL_MAX;
    return VAL_MIN;
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_element(input logic signed [DATA_W-1:0] v, input logic last);
    int gap;
    gap = in_idle_on ? idle_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{value_in: v, is_last: last};
    do @(posedge clk); while (!in_ready);
    elems_sent++;
  endtask

  task automatic send_set();
    int i;
    for (i = 0; i < set_vals.size(); i++) send_element(set_vals[i], i == set_vals.size() - 1);
    sets_sent++;
    set_vals.delete();
  endtask

  task automatic test_single_sets();
    set_vals.push_back(VAL_MIN);
    send_set();
    set_vals.push_back(VAL_MAX);
    send_set();
    set_vals.push_back(0);
    send_set();
    set_vals.push_back(-1);
    send_set();
  endtask

  task automatic test_mixed_extremes();
    set_vals = {VAL_MAX, 32'sh5555_5555, -1, VAL_MIN, 0, 32'shAAAA_AAAA, 1};
    send_set();
  endtask

  task automatic test_equal_values();
    set_vals = {7, -2, 7, 7, -2};
    send_set();
  endtask

  // One set, all in reverse order
  task automatic test_descending();
    set_vals = {40, 30, 20, 10, -10};
    send_set();
  endtask

  // Exactly full, then two beyond capacity so the closing element is dropped
  task automatic test_store_full();
    repeat (CAPACITY) set_vals.push_back(rand_element());
    send_set();
    repeat (CAPACITY + 2) set_vals.push_back(rand_element());
    send_set();
  endtask

  task automatic test_random_sets(input int target);
    int start;
    int len;
    int r;
    start = elems_sent;
    while (elems_sent - start < target) begin
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 19);
      if (r < 17) len = $urandom_range(1, 8);
      else if (r < 19) len = $urandom_range(9, CAPACITY);
      else len = $urandom_range(CAPACITY + 1, CAPACITY + 4);
      repeat (len) set_vals.push_back(rand_element());
      send_set();
    end
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_single_sets();
    test_mixed_extremes();
    test_equal_values();
    test_descending();
    test_store_full();
    test_random_sets(130);
    in_valid <= 1'b0;
    // let the last accepted transaction reach the model before waiting on it
    @(posedge clk);
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d elements in %0d sets: single, extreme, repeated, reversed, full and",
             elems_sent, sets_sent);
    $display("overflowing sets plus random ones; %0d sorted results checked, %0d sets overflowed.",
             results_seen, overflow_sets);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: merge_and_sort_two_arrays.f
+incdir+src
src/mast_pkg.sv
src/mast_cell.sv
src/merge_and_sort_two_arrays.sv
verif/tb_top.sv
